// ===== design/tsbf_pkg.sv =====
// Package for the TCP scan and blocklist filter.
// Holds item codes, frame offsets, drop reasons and the queue entry type.
// No dependencies; the top, front end, queue and back end refer to it by scoped names.
package tsbf_pkg;

    localparam int DEF_BLOCK_ENTRIES = 16;
    localparam int DEF_COUNT_BITS    = 14;
    localparam int QUEUE_DEPTH       = 4;

    // Input item kinds.
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    // Operations carried through the queue.
    localparam logic [1:0] OP_JUDGE  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Drop reasons.
    localparam logic [2:0] REASON_NONE      = 3'd0;
    localparam logic [2:0] REASON_SHORT_ETH = 3'd1;
    localparam logic [2:0] REASON_SHORT_IP  = 3'd2;
    localparam logic [2:0] REASON_SHORT_TCP = 3'd3;
    localparam logic [2:0] REASON_XMAS      = 3'd4;
    localparam logic [2:0] REASON_FIN       = 3'd5;
    localparam logic [2:0] REASON_NULL      = 3'd6;
    localparam logic [2:0] REASON_BLOCKED   = 3'd7;

    // Frame layout and length limits, in bytes.
    localparam int ETH_LEN       = 14;
    localparam int IP_MIN_END    = 34;
    localparam int TCP_LEN       = 20;
    localparam int POS_IHL       = 14;
    localparam int POS_PROTO     = 23;
    localparam int POS_SRC_FIRST = 26;
    localparam int POS_SRC_LAST  = 29;
    localparam int OFS_PORT_HI   = 2;
    localparam int OFS_PORT_LO   = 3;
    localparam int OFS_FLAGS     = 13;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] FLAGS_XMAS = 8'h29;
    localparam logic [7:0] FLAGS_FIN  = 8'h01;
    localparam logic [7:0] FLAGS_NULL = 8'h00;
    localparam int FLAG_SYN_BIT = 1;
    localparam int FLAG_ACK_BIT = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] addr;     // source address for a judge, table address otherwise
        logic        lookup;   // the verdict still depends on the blocklist
        logic        verdict;
        logic [2:0]  reason;
        logic        report;
        logic [15:0] port;
    } qentry_t;

endpackage

// ===== design/tsbf_in_if.sv =====
// Input channel of the filter: frame bytes and blocklist edits.
// Stand-alone interface; no dependencies.
interface tsbf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] block_address;

    modport source (output valid, kind, data_byte, last, block_address, input ready);
    modport sink   (input valid, kind, data_byte, last, block_address, output ready);
endinterface

// ===== design/tsbf_out_if.sv =====
// Result channel of the filter: one verdict beat per frame.
// Stand-alone interface; no dependencies.
interface tsbf_out_if;
    logic        valid;
    logic        ready;
    logic        verdict;
    logic [2:0]  reason;
    logic        report;
    logic [15:0] dest_port;
    logic [31:0] source_ip;

    modport source (output valid, verdict, reason, report, dest_port, source_ip, input ready);
    modport sink   (input valid, verdict, reason, report, dest_port, source_ip, output ready);
endinterface

// ===== design/tcp_scan_and_blocklist_filter_top.sv =====
// TCP scan and blocklist filter, top level.
// Takes one input beat per cycle while the queue is not full; the final byte of a frame
// yields its verdict beat through the queue and the back end's output register when the
// result side is not stalled, one verdict per cycle at most. The rate is set by the front
// end's byte capture and the back end's lookup. A four-entry queue parts the two ends.
// Reset is asynchronous, active low, and empties the blocklist, the queue and the frame capture at once.
module tcp_scan_and_blocklist_filter_top #(
    parameter int BLOCK_ENTRIES = tsbf_pkg::DEF_BLOCK_ENTRIES,
    parameter int COUNT_BITS    = tsbf_pkg::DEF_COUNT_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    tsbf_in_if.sink    item,
    tsbf_out_if.source result
);

    logic              push;
    logic              pop;
    logic              full;
    logic              nonempty;
    tsbf_pkg::qentry_t push_data;
    tsbf_pkg::qentry_t head;

    tsbf_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .queue_full (full),
        .push       (push),
        .push_data  (push_data)
    );

    tsbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .nonempty  (nonempty),
        .head      (head)
    );

    tsbf_back #(
        .BLOCK_ENTRIES (BLOCK_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .nonempty (nonempty),
        .head     (head),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== design/tsbf_front.sv =====
// Front end: accepts input beats, captures header fields and classifies frames.
// Depends on tsbf_pkg and tsbf_in_if; pushes judge and table operations to the queue.
module tsbf_front #(
    parameter int COUNT_BITS = tsbf_pkg::DEF_COUNT_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    tsbf_in_if.sink           item,
    input  logic              queue_full,
    output logic              push,
    output tsbf_pkg::qentry_t push_data
);

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [3:0]            hw_reg, hw_next;
    logic [7:0]            proto_reg, proto_next;
    logic [31:0]           src_reg, src_next;
    logic [7:0]            flags_reg, flags_next;
    logic [15:0]           port_reg, port_next;
    logic [COUNT_BITS-1:0] tcp_start;
    logic [COUNT_BITS-1:0] tcp_end;
    logic                  accept;
    logic                  is_frame;
    logic                  is_edit;

    assign item.ready = !queue_full;
    assign accept     = item.valid && item.ready;
    assign is_frame   = item.kind == tsbf_pkg::KIND_FRAME;
    assign is_edit    = item.kind == tsbf_pkg::KIND_INSERT
                     || item.kind == tsbf_pkg::KIND_REMOVE;

    assign tcp_start = COUNT_BITS'(tsbf_pkg::ETH_LEN) + COUNT_BITS'({hw_reg, 2'b00});

    // Field values with the current byte folded in.
    always_comb
    begin
        hw_next    = hw_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        flags_next = flags_reg;
        port_next  = port_reg;
        if (count_reg == COUNT_BITS'(tsbf_pkg::POS_IHL))
        begin
            hw_next = item.data_byte[3:0];
        end
        if (count_reg == COUNT_BITS'(tsbf_pkg::POS_PROTO))
        begin
            proto_next = item.data_byte;
        end
        if (count_reg >= COUNT_BITS'(tsbf_pkg::POS_SRC_FIRST)
            && count_reg <= COUNT_BITS'(tsbf_pkg::POS_SRC_LAST))
        begin
            src_next = {src_reg[23:0], item.data_byte};
        end
        if (count_reg == tcp_start + COUNT_BITS'(tsbf_pkg::OFS_PORT_HI))
        begin
            port_next[15:8] = item.data_byte;
        end
        if (count_reg == tcp_start + COUNT_BITS'(tsbf_pkg::OFS_PORT_LO))
        begin
            port_next[7:0] = item.data_byte;
        end
        if (count_reg == tcp_start + COUNT_BITS'(tsbf_pkg::OFS_FLAGS))
        begin
            flags_next = item.data_byte;
        end
    end

    assign count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign tcp_end    = COUNT_BITS'(tsbf_pkg::ETH_LEN + tsbf_pkg::TCP_LEN)
                      + COUNT_BITS'({hw_next, 2'b00});

    // Classification of the frame as it stands after this byte. Everything but
    // the blocklist lookup is settled here.
    always_comb
    begin
        push_data         = '0;
        push_data.op      = tsbf_pkg::OP_JUDGE;
        push_data.addr    = src_next;
        push_data.verdict = 1'b1;
        if (!is_frame)
        begin
            push_data.op      = (item.kind == tsbf_pkg::KIND_INSERT)
                              ? tsbf_pkg::OP_INSERT : tsbf_pkg::OP_REMOVE;
            push_data.addr    = item.block_address;
            push_data.verdict = 1'b0;
        end
        else if (count_next < COUNT_BITS'(tsbf_pkg::ETH_LEN))
        begin
            push_data.reason = tsbf_pkg::REASON_SHORT_ETH;
        end
        else if (count_next < COUNT_BITS'(tsbf_pkg::IP_MIN_END))
        begin
            push_data.reason = tsbf_pkg::REASON_SHORT_IP;
        end
        else if (proto_next != tsbf_pkg::PROTO_TCP)
        begin
            push_data.verdict = 1'b0;
        end
        else if (count_next < tcp_end)
        begin
            push_data.reason = tsbf_pkg::REASON_SHORT_TCP;
        end
        else if ((flags_next & tsbf_pkg::FLAGS_XMAS) == tsbf_pkg::FLAGS_XMAS)
        begin
            push_data.reason = tsbf_pkg::REASON_XMAS;
        end
        else if (flags_next == tsbf_pkg::FLAGS_FIN)
        begin
            push_data.reason = tsbf_pkg::REASON_FIN;
        end
        else if (flags_next == tsbf_pkg::FLAGS_NULL)
        begin
            push_data.reason = tsbf_pkg::REASON_NULL;
        end
        else
        begin
            push_data.verdict = 1'b0;
            push_data.lookup  = 1'b1;
            push_data.report  = !flags_next[tsbf_pkg::FLAG_SYN_BIT]
                             || flags_next[tsbf_pkg::FLAG_ACK_BIT];
            push_data.port    = push_data.report ? port_next : 16'd0;
        end
    end

    assign push = accept && ((is_frame && item.last) || is_edit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hw_reg    <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            flags_reg <= '0;
            port_reg  <= '0;
        end
        else if (accept && is_frame)
        begin
            if (item.last)
            begin
                count_reg <= '0;
                hw_reg    <= '0;
                proto_reg <= '0;
                src_reg   <= '0;
                flags_reg <= '0;
                port_reg  <= '0;
            end
            else
            begin
                count_reg <= count_next;
                hw_reg    <= hw_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                flags_reg <= flags_next;
                port_reg  <= port_next;
            end
        end
    end

endmodule

// ===== design/tsbf_queue.sv =====
// Short in-order queue between the front end and the back end.
// Depends on tsbf_pkg for the entry type and depth.
module tsbf_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsbf_pkg::qentry_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              nonempty,
    output tsbf_pkg::qentry_t head
);

    localparam int PTR_W = (tsbf_pkg::QUEUE_DEPTH > 1) ? $clog2(tsbf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(tsbf_pkg::QUEUE_DEPTH + 1);

    tsbf_pkg::qentry_t slot_reg [tsbf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = count_reg == CNT_W'(tsbf_pkg::QUEUE_DEPTH);
    assign nonempty = count_reg != '0;
    assign head     = slot_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(tsbf_pkg::QUEUE_DEPTH - 1))
                       ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(tsbf_pkg::QUEUE_DEPTH - 1))
                       ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== design/tsbf_back.sv =====
// Back end: holds the source blocklist, applies edits and finishes verdicts.
// Depends on tsbf_pkg and tsbf_out_if; drains the queue one entry per cycle, judges only while the result is free.
module tsbf_back #(
    parameter int BLOCK_ENTRIES = tsbf_pkg::DEF_BLOCK_ENTRIES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              nonempty,
    input  tsbf_pkg::qentry_t head,
    output logic              pop,
    tsbf_out_if.source        result
);

    logic [BLOCK_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              addr_reg [BLOCK_ENTRIES];
    logic [BLOCK_ENTRIES-1:0] hit_vec;
    logic [BLOCK_ENTRIES-1:0] free_vec;
    logic [BLOCK_ENTRIES-1:0] first_free;
    logic                     hit_any;
    logic                     do_insert;
    logic                     do_remove;
    logic                     do_judge;
    logic                     out_valid_reg;
    logic                     verdict_reg;
    logic [2:0]               reason_reg;
    logic                     report_reg;
    logic [15:0]              port_reg;
    logic [31:0]              ip_reg;

    // All entries are compared against the head address in parallel.
    always_comb
    begin
        for (int i = 0; i < BLOCK_ENTRIES; i++)
        begin
            hit_vec[i] = valid_reg[i] && (addr_reg[i] == head.addr);
        end
    end

    assign hit_any    = |hit_vec;
    assign free_vec   = ~valid_reg;
    assign first_free = free_vec & ((~free_vec) + BLOCK_ENTRIES'(1));

    always_comb
    begin
        do_judge  = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        unique case (head.op)
            tsbf_pkg::OP_JUDGE:  do_judge  = nonempty;
            tsbf_pkg::OP_INSERT: do_insert = nonempty;
            tsbf_pkg::OP_REMOVE: do_remove = nonempty;
            default:             ;
        endcase
    end

    // A judge needs a free output register; table edits always drain.
    assign pop = do_insert || do_remove || (do_judge && (!out_valid_reg || result.ready));

    always_comb
    begin
        valid_next = valid_reg;
        if (do_insert && !hit_any)
        begin
            valid_next = valid_reg | first_free;
        end
        else if (do_remove)
        begin
            valid_next = valid_reg & ~hit_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop && do_judge)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BLOCK_ENTRIES; i++)
        begin
            if (do_insert && !hit_any && first_free[i])
            begin
                addr_reg[i] <= head.addr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && do_judge)
        begin
            if (head.lookup && hit_any)
            begin
                verdict_reg <= 1'b1;
                reason_reg  <= tsbf_pkg::REASON_BLOCKED;
                report_reg  <= 1'b0;
                port_reg    <= '0;
                ip_reg      <= '0;
            end
            else
            begin
                verdict_reg <= head.verdict;
                reason_reg  <= head.reason;
                report_reg  <= head.report;
                port_reg    <= head.port;
                ip_reg      <= head.report ? head.addr : 32'd0;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.verdict   = verdict_reg;
    assign result.reason    = reason_reg;
    assign result.report    = report_reg;
    assign result.dest_port = port_reg;
    assign result.source_ip = ip_reg;

endmodule
